// ----- hdl/ccr_pkg.sv -----
// Shared types, constants and helpers for the closed Catmull-Rom evaluator.
`timescale 1ns / 1ps
package ccr_pkg;

   localparam int DEF_MAX_POINTS = 16;
   localparam int NUM_W = 49;                 // divider numerator width
   localparam int DEN_W = 35;                 // divider denominator width
   localparam logic [30:0] GAP_RESET = 31'd32768;
   localparam logic [16:0] SCALE_RESET = 17'd58982;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_EVAL = 1'b1
   } command_type;

   typedef enum logic {
      CSR_GAP   = 1'b0,
      CSR_SCALE = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_FEW  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_RD,
      OP_TZERO,
      OP_DIV_SLOPE,
      OP_SAVE_SLOPE,
      OP_TMUL,
      OP_TWR,
      OP_LOOP,
      OP_DIV_MOD,
      OP_MOD_SAVE,
      OP_SHIFT,
      OP_SEG,
      OP_DIV_U,
      OP_U_SAVE,
      OP_PREP,
      OP_MUL,
      OP_MWB,
      OP_ACC,
      OP_RESULT
   } op_type;

   typedef enum logic [3:0] {
      MS_A,
      MS_U2,
      MS_U3,
      MS_SU,
      MS_SU2,
      MS_B,
      MS_C,
      MS_E,
      MS_F
   } mstep_type;

   typedef struct packed {
      op_type    op;
      logic [1:0] slot;
      logic      sel_next;
      logic      wrap;
      logic      close;
      logic      coord;
      logic      first;
      logic      store;
      mstep_type mstep;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic hit;
      logic dz;
      logic loop_pos;
   } stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

endpackage

// ----- hdl/ccr_div.sv -----
// Radix-2 restoring signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ccr_div #(
   parameter int NW = 49,
   parameter int DW = 35
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic                 busy,
   output logic signed [NW:0]   quo,
   output logic [DW-1:0]        rem
);
   localparam int CNT_W = $clog2(NW + 1);

   logic                busy_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [NW-1:0]       acc_ff;
   logic [DW-1:0]       rem_ff;
   logic [DW-1:0]       dmag_ff;
   logic                neg_ff;
   logic [DW:0]         trial;
   logic                ge;
   logic [NW-1:0]       nmag;
   logic [DW-1:0]       dmag;

   assign nmag  = num[NW-1] ? NW'(-num) : NW'(num);
   assign dmag  = den[DW-1] ? DW'(-den) : DW'(den);
   assign trial = {rem_ff, acc_ff[NW-1]};
   assign ge    = trial >= {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NW);
         acc_ff  <= nmag;
         rem_ff  <= '0;
         dmag_ff <= dmag;
         neg_ff  <= num[NW-1] ^ den[DW-1];
      end else if (busy_ff) begin
         rem_ff <= ge ? DW'(trial - {1'b0, dmag_ff}) : DW'(trial);
         acc_ff <= {acc_ff[NW-2:0], ge};
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign quo  = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
   assign rem  = rem_ff;
endmodule

// ----- hdl/ccr_dp.sv -----
// Datapath: point tables, operand slots, dividers, multipliers and result registers.
`timescale 1ns / 1ps
module ccr_dp #(
   parameter int MAX_POINTS = 16,
   parameter int AW = $clog2(MAX_POINTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  ccr_pkg::cmd_type    cmd,
   input  logic [AW-1:0]       addr,
   input  logic signed [31:0]  coord_x,
   input  logic signed [31:0]  coord_y,
   input  logic [30:0]         time_value,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [30:0]         csr_wdata,
   output ccr_pkg::stat_type   stat,
   output logic signed [31:0]  pos_x,
   output logic signed [31:0]  pos_y
);
   import ccr_pkg::*;

   logic signed [31:0] px_mem [MAX_POINTS];
   logic signed [31:0] py_mem [MAX_POINTS];
   logic signed [31:0] pt_mem [MAX_POINTS];
   logic signed [31:0] tx_mem [MAX_POINTS];
   logic signed [31:0] ty_mem [MAX_POINTS];

   logic signed [31:0] slot_x_ff [3];
   logic signed [31:0] slot_y_ff [3];
   logic signed [31:0] slot_t_ff [3];
   logic signed [31:0] slot_vx_ff [3];
   logic signed [31:0] slot_vy_ff [3];

   logic [30:0]        gap_ff, start_ff, tv_ff, t_ff;
   logic [16:0]        scale_ff;
   logic signed [31:0] snx_ff, sny_ff, spx_ff, spy_ff;
   logic signed [50:0] tpx_ff, tpy_ff;
   logic signed [33:0] loop_ff;
   logic signed [31:0] s_ff, u_ff;
   logic signed [34:0] d_ff;
   logic signed [31:0] dpt_ff, w1_ff, w2_ff;
   logic signed [31:0] u2_ff, u3_ff, su_ff, su2_ff;
   logic signed [31:0] ta_ff, tb_ff, tc_ff, te_ff, tf_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] posx_ff, posy_ff, outx_ff, outy_ff;

   // slope operands
   logic signed [31:0] hx, lx, hy, ly, ht, lt;
   logic signed [32:0] dpx, dpy, dtt;
   logic signed [34:0] dt;
   logic signed [NUM_W-1:0] numx, numy;
   logic signed [DEN_W-1:0] denx;
   logic startx, starty, busyx, busyy;
   logic signed [NUM_W:0] quox, quoy;
   logic [DEN_W-1:0] remx, remy;

   logic signed [31:0] ma, mb, qv;
   logic signed [31:0] p0, p1, v0, v1;
   logic signed [37:0] acc;
   logic signed [33:0] t1;
   logic signed [32:0] tsg, relt;
   logic signed [17:0] scale_s;
   logic signed [32:0] sumx, sumy;

   assign hx = cmd.sel_next ? slot_x_ff[2] : slot_x_ff[1];
   assign lx = cmd.sel_next ? slot_x_ff[1] : slot_x_ff[0];
   assign hy = cmd.sel_next ? slot_y_ff[2] : slot_y_ff[1];
   assign ly = cmd.sel_next ? slot_y_ff[1] : slot_y_ff[0];
   assign ht = cmd.sel_next ? slot_t_ff[2] : slot_t_ff[1];
   assign lt = cmd.sel_next ? slot_t_ff[1] : slot_t_ff[0];
   assign dpx = 33'(hx) - 33'(lx);
   assign dpy = 33'(hy) - 33'(ly);
   assign dtt = 33'(ht) - 33'(lt);
   assign dt  = cmd.wrap ? $signed({4'b0, gap_ff}) : 35'(dtt);

   always_comb begin
      case (cmd.op)
         OP_DIV_MOD: begin
            numx = $signed({18'b0, tv_ff});
            denx = 35'(loop_ff);
         end
         OP_DIV_U: begin
            numx = NUM_W'($signed({s_ff, 16'b0}));
            denx = d_ff;
         end
         default: begin
            numx = {dpx, 16'b0};
            denx = dt;
         end
      endcase
   end
   assign numy   = {dpy, 16'b0};
   assign startx = (cmd.op == OP_DIV_SLOPE) || (cmd.op == OP_DIV_MOD) || (cmd.op == OP_DIV_U);
   assign starty = (cmd.op == OP_DIV_SLOPE);

   ccr_div #(.NW(NUM_W), .DW(DEN_W)) u_div_x (
      .clock(clock), .reset(reset), .start(startx), .num(numx), .den(denx),
      .busy(busyx), .quo(quox), .rem(remx)
   );
   ccr_div #(.NW(NUM_W), .DW(DEN_W)) u_div_y (
      .clock(clock), .reset(reset), .start(starty), .num(numy), .den(dt),
      .busy(busyy), .quo(quoy), .rem(remy)
   );

   assign p0 = cmd.coord ? slot_y_ff[0] : slot_x_ff[0];
   assign p1 = cmd.coord ? slot_y_ff[1] : slot_x_ff[1];
   assign v0 = cmd.coord ? slot_vy_ff[0] : slot_vx_ff[0];
   assign v1 = cmd.coord ? slot_vy_ff[1] : slot_vx_ff[1];

   always_comb begin
      case (cmd.mstep)
         MS_A:    begin ma = v0;     mb = s_ff;   end
         MS_U2:   begin ma = u_ff;   mb = u_ff;   end
         MS_U3:   begin ma = u2_ff;  mb = u_ff;   end
         MS_SU:   begin ma = s_ff;   mb = u_ff;   end
         MS_SU2:  begin ma = s_ff;   mb = u2_ff;  end
         MS_B:    begin ma = dpt_ff; mb = u2_ff;  end
         MS_C:    begin ma = w1_ff;  mb = su_ff;  end
         MS_E:    begin ma = dpt_ff; mb = u3_ff;  end
         MS_F:    begin ma = w2_ff;  mb = su2_ff; end
         default: begin ma = '0;     mb = '0;     end
      endcase
   end
   assign qv = sat32(64'(prod_ff >>> 16));

   always_comb begin
      if (stat.dz) begin
         acc = 38'(p0) + 38'(ta_ff);
      end else begin
         acc = 38'(p0) + 38'(ta_ff) + 38'(tb_ff) * 38'sd3 - 38'(tc_ff)
               - 38'(te_ff) * 38'sd2 + 38'(tf_ff);
      end
   end

   assign t1      = cmd.close ? loop_ff : 34'(slot_t_ff[1]);
   assign tsg     = $signed({2'b0, t_ff});
   assign relt    = $signed({2'b0, time_value}) - $signed({2'b0, start_ff});
   assign scale_s = $signed({1'b0, scale_ff});
   assign sumx    = 33'(snx_ff) + 33'(spx_ff);
   assign sumy    = 33'(sny_ff) + 33'(spy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= GAP_RESET;
         scale_ff <= SCALE_RESET;
         start_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAP:   gap_ff   <= csr_wdata;
               CSR_SCALE: scale_ff <= csr_wdata[16:0];
               default:   ;
            endcase
         end
         if (cmd.op == OP_ACCEPT && cmd.store && cmd.first) begin
            start_ff <= time_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            tv_ff   <= time_value;
            t_ff    <= time_value;
            posx_ff <= '0;
            posy_ff <= '0;
            if (cmd.store) begin
               px_mem[addr] <= coord_x;
               py_mem[addr] <= coord_y;
               pt_mem[addr] <= cmd.first ? 32'sd0 : relt[31:0];
            end
         end
         OP_RD: begin
            slot_x_ff[cmd.slot]  <= px_mem[addr];
            slot_y_ff[cmd.slot]  <= py_mem[addr];
            slot_t_ff[cmd.slot]  <= pt_mem[addr];
            slot_vx_ff[cmd.slot] <= tx_mem[addr];
            slot_vy_ff[cmd.slot] <= ty_mem[addr];
         end
         OP_TZERO: begin
            tx_mem[addr] <= '0;
            ty_mem[addr] <= '0;
         end
         OP_SAVE_SLOPE: begin
            if (cmd.sel_next) begin
               snx_ff <= (dt == '0) ? 32'sd0 : sat32(64'(quox));
               sny_ff <= (dt == '0) ? 32'sd0 : sat32(64'(quoy));
            end else begin
               spx_ff <= (dt == '0) ? 32'sd0 : sat32(64'(quox));
               spy_ff <= (dt == '0) ? 32'sd0 : sat32(64'(quoy));
            end
         end
         OP_TMUL: begin
            tpx_ff <= 51'(sumx) * 51'(scale_s);
            tpy_ff <= 51'(sumy) * 51'(scale_s);
         end
         OP_TWR: begin
            tx_mem[addr] <= sat32(64'(tpx_ff >>> 16));
            ty_mem[addr] <= sat32(64'(tpy_ff >>> 16));
         end
         OP_LOOP: loop_ff <= 34'(slot_t_ff[0]) + $signed({3'b0, gap_ff});
         OP_MOD_SAVE: t_ff <= remx[30:0];
         OP_SHIFT: begin
            slot_x_ff[0]  <= slot_x_ff[1];
            slot_y_ff[0]  <= slot_y_ff[1];
            slot_t_ff[0]  <= slot_t_ff[1];
            slot_vx_ff[0] <= slot_vx_ff[1];
            slot_vy_ff[0] <= slot_vy_ff[1];
         end
         OP_SEG: begin
            s_ff <= sat32(64'(tsg - 33'(slot_t_ff[0])));
            d_ff <= 35'(t1) - 35'(slot_t_ff[0]);
         end
         OP_U_SAVE: u_ff <= sat32(64'(quox));
         OP_PREP: begin
            dpt_ff <= sat32(64'(33'(p1) - 33'(p0)));
            w1_ff  <= sat32(64'(34'(v1) + 34'(v0) * 34'sd2));
            w2_ff  <= sat32(64'(33'(v1) + 33'(v0)));
         end
         OP_MUL: prod_ff <= 64'(ma) * 64'(mb);
         OP_MWB: begin
            case (cmd.mstep)
               MS_A:    ta_ff  <= qv;
               MS_U2:   u2_ff  <= qv;
               MS_U3:   u3_ff  <= qv;
               MS_SU:   su_ff  <= qv;
               MS_SU2:  su2_ff <= qv;
               MS_B:    tb_ff  <= qv;
               MS_C:    tc_ff  <= qv;
               MS_E:    te_ff  <= qv;
               MS_F:    tf_ff  <= qv;
               default: ;
            endcase
         end
         OP_ACC: begin
            if (cmd.coord) posy_ff <= sat32(64'(acc));
            else posx_ff <= sat32(64'(acc));
         end
         OP_RESULT: begin
            outx_ff <= posx_ff;
            outy_ff <= posy_ff;
         end
         default: ;
      endcase
   end

   assign stat.div_done = !busyx && !busyy;
   assign stat.hit      = (slot_t_ff[0] <= 32'(tsg)) && (32'(tsg) <= slot_t_ff[1]);
   assign stat.dz       = (d_ff == '0);
   assign stat.loop_pos = (loop_ff > 34'sd0);
   assign pos_x = outx_ff;
   assign pos_y = outy_ff;
endmodule

// ----- hdl/ccr_ctrl.sv -----
// Controller: sequences add, tangent refresh, loop wrap, segment search and evaluation.
`timescale 1ns / 1ps
module ccr_ctrl #(
   parameter int MAX_POINTS = 16,
   parameter int AW = $clog2(MAX_POINTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_cmd,
   output logic                 req_tready,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [1:0]           rsp_status,
   input  ccr_pkg::stat_type    stat,
   output ccr_pkg::cmd_type     cmd,
   output logic [AW-1:0]        addr
);
   import ccr_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_TZERO, S_TRDA, S_TRDB, S_TRDC, S_TDIVN, S_TWAITN, S_TDIVP, S_TWAITP,
      S_TMUL, S_TWR, S_ERDL, S_ELOOP, S_EMOD, S_EMODW, S_ES0, S_ESB, S_ECMP, S_ECA,
      S_ECB, S_ESEG, S_EU, S_EUW, S_EPREP, S_EMUL, S_EMWB, S_EACC, S_FIN
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] idx_ff;
   logic        close_ff, coord_ff, rsp_valid_ff;
   mstep_type   step_ff;
   status_type  code_ff, rsp_status_ff;
   logic [AW-1:0] last, prv, nxt;
   logic        full, few, out_free;

   assign last     = AW'(count_ff - CW'(1));
   assign prv      = (idx_ff == '0) ? last : idx_ff - AW'(1);
   assign nxt      = (idx_ff == last) ? '0 : idx_ff + AW'(1);
   assign full     = (count_ff == CW'(MAX_POINTS));
   assign few      = (count_ff < CW'(2));
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd = '0;
      cmd.op = OP_NONE;
      cmd.mstep = step_ff;
      cmd.close = close_ff;
      cmd.coord = coord_ff;
      addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op    = OP_ACCEPT;
               cmd.first = (count_ff == '0);
               cmd.store = (req_cmd == CMD_ADD) && !full;
               addr      = AW'(count_ff);
            end
         end
         S_TZERO: cmd.op = OP_TZERO;
         S_TRDA: begin cmd.op = OP_RD; cmd.slot = 2'd0; addr = prv; end
         S_TRDB: begin cmd.op = OP_RD; cmd.slot = 2'd1; addr = idx_ff; end
         S_TRDC: begin cmd.op = OP_RD; cmd.slot = 2'd2; addr = nxt; end
         S_TDIVN: begin
            cmd.op = OP_DIV_SLOPE; cmd.sel_next = 1'b1; cmd.wrap = (idx_ff == last);
         end
         S_TWAITN: begin
            cmd.sel_next = 1'b1; cmd.wrap = (idx_ff == last);
            if (stat.div_done) cmd.op = OP_SAVE_SLOPE;
         end
         S_TDIVP: begin cmd.op = OP_DIV_SLOPE; cmd.wrap = (idx_ff == '0); end
         S_TWAITP: begin
            cmd.wrap = (idx_ff == '0);
            if (stat.div_done) cmd.op = OP_SAVE_SLOPE;
         end
         S_TMUL: cmd.op = OP_TMUL;
         S_TWR: begin cmd.op = OP_TWR; addr = idx_ff; end
         S_ERDL: begin cmd.op = OP_RD; cmd.slot = 2'd0; addr = last; end
         S_ELOOP: cmd.op = OP_LOOP;
         S_EMOD: if (stat.loop_pos) cmd.op = OP_DIV_MOD;
         S_EMODW: if (stat.div_done) cmd.op = OP_MOD_SAVE;
         S_ES0: begin cmd.op = OP_RD; cmd.slot = 2'd0; addr = '0; end
         S_ESB: begin cmd.op = OP_RD; cmd.slot = 2'd1; addr = idx_ff + AW'(1); end
         S_ECMP: if (!stat.hit) cmd.op = OP_SHIFT;
         S_ECA: begin cmd.op = OP_RD; cmd.slot = 2'd0; addr = last; end
         S_ECB: begin cmd.op = OP_RD; cmd.slot = 2'd1; addr = '0; end
         S_ESEG: cmd.op = OP_SEG;
         S_EU: if (!stat.dz) cmd.op = OP_DIV_U;
         S_EUW: if (stat.div_done) cmd.op = OP_U_SAVE;
         S_EPREP: cmd.op = OP_PREP;
         S_EMUL: cmd.op = OP_MUL;
         S_EMWB: cmd.op = OP_MWB;
         S_EACC: cmd.op = OP_ACC;
         S_FIN: if (out_free) cmd.op = OP_RESULT;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         close_ff      <= 1'b0;
         coord_ff      <= 1'b0;
         step_ff       <= MS_A;
         code_ff       <= ST_OK;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
      end else begin
         if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  idx_ff   <= '0;
                  close_ff <= 1'b0;
                  coord_ff <= 1'b0;
                  code_ff  <= ST_OK;
                  if (req_cmd == CMD_ADD) begin
                     if (full) begin
                        code_ff  <= ST_FULL;
                        state_ff <= S_FIN;
                     end else begin
                        count_ff <= count_ff + CW'(1);
                        state_ff <= (count_ff == '0) ? S_TZERO : S_TRDA;
                     end
                  end else if (few) begin
                     code_ff  <= ST_FEW;
                     state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_ERDL;
                  end
               end
            end
            S_TZERO: state_ff <= S_FIN;
            S_TRDA: state_ff <= S_TRDB;
            S_TRDB: state_ff <= S_TRDC;
            S_TRDC: state_ff <= S_TDIVN;
            S_TDIVN: state_ff <= S_TWAITN;
            S_TWAITN: if (stat.div_done) state_ff <= S_TDIVP;
            S_TDIVP: state_ff <= S_TWAITP;
            S_TWAITP: if (stat.div_done) state_ff <= S_TMUL;
            S_TMUL: state_ff <= S_TWR;
            S_TWR: begin
               if (idx_ff == last) begin
                  state_ff <= S_FIN;
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= S_TRDA;
               end
            end
            S_ERDL: state_ff <= S_ELOOP;
            S_ELOOP: state_ff <= S_EMOD;
            S_EMOD: state_ff <= stat.loop_pos ? S_EMODW : S_ES0;
            S_EMODW: if (stat.div_done) state_ff <= S_ES0;
            S_ES0: state_ff <= S_ESB;
            S_ESB: state_ff <= S_ECMP;
            S_ECMP: begin
               if (stat.hit) begin
                  state_ff <= S_ESEG;
               end else if (idx_ff + AW'(1) == last) begin
                  close_ff <= 1'b1;
                  state_ff <= S_ECA;
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= S_ESB;
               end
            end
            S_ECA: state_ff <= S_ECB;
            S_ECB: state_ff <= S_ESEG;
            S_ESEG: state_ff <= S_EU;
            S_EU: state_ff <= stat.dz ? S_EPREP : S_EUW;
            S_EUW: if (stat.div_done) state_ff <= S_EPREP;
            S_EPREP: begin
               step_ff  <= MS_A;
               state_ff <= S_EMUL;
            end
            S_EMUL: state_ff <= S_EMWB;
            S_EMWB: begin
               if (step_ff == MS_F || (step_ff == MS_A && stat.dz)) begin
                  state_ff <= S_EACC;
               end else begin
                  step_ff  <= mstep_type'(step_ff + 4'd1);
                  state_ff <= S_EMUL;
               end
            end
            S_EACC: begin
               if (coord_ff) begin
                  state_ff <= S_FIN;
               end else begin
                  coord_ff <= 1'b1;
                  state_ff <= S_EPREP;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= code_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
endmodule

// ----- hdl/closed_catmull_rom_spline_eval_unit.sv -----
// Top level of the closed Catmull-Rom curve evaluator.
//
//  channel  | direction | handshake         | contents
//  req_     | in        | tvalid/tready     | tuser: command; tdata: coord_x, coord_y, time_value
//  rsp_     | out       | tvalid/tready     | tdata: pos_x, pos_y, status
//  csr_     | in        | we (no wait)      | index 0 closing_gap, 1 tangent_scale
//
// One request at a time. An add refreshes the tangent of every stored point, using
// the two dividers to form the chord slopes of each point to its neighbours. An
// evaluate scans the stored points for the segment, then uses up to two divisions
// and the shared multiplier for each of the two coordinates.
// Synchronous reset empties the table. A result held by a stalled rsp_ side does
// not block acceptance of the next request.
`timescale 1ns / 1ps
module closed_catmull_rom_spline_eval_unit #(
   parameter int MAX_POINTS = ccr_pkg::DEF_MAX_POINTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,    // command
   input  logic [95:0] req_tdata,    // coord_x, coord_y, time_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // pos_x, pos_y, status
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);
   import ccr_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);

   cmd_type            cmd;
   stat_type           stat;
   logic [AW-1:0]      addr;
   logic [1:0]         status;
   logic signed [31:0] pos_x, pos_y;

   ccr_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_cmd(req_tuser), .req_tready(req_tready),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp_status(status),
      .stat(stat), .cmd(cmd), .addr(addr)
   );

   ccr_dp #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .addr(addr),
      .coord_x(req_tdata[31:0]), .coord_y(req_tdata[63:32]),
      .time_value(req_tdata[94:64]),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .stat(stat), .pos_x(pos_x), .pos_y(pos_y)
   );

   assign rsp_tdata = {6'b0, status, pos_y, pos_x};
endmodule
